// ===== rtl/core/l2tpcs_pkg.sv =====
`timescale 1ns / 1ps

package l2tpcs_pkg;

  typedef enum logic [1:0] {
    OP_RX_CTRL = 2'd0,
    OP_RX_DATA = 2'd1,
    OP_TICK    = 2'd2,
    OP_SEND    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_INORDER = 3'd0,
    KIND_DUP     = 3'd1,
    KIND_OOO     = 3'd2,
    KIND_DATA    = 3'd3,
    KIND_ZLB     = 3'd4,
    KIND_NONE    = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    TS_WAIT = 2'd0,
    TS_EST  = 2'd1,
    TS_TERM = 2'd2
  } tun_state_t;

  localparam logic [3:0]  MSG_SCCCN        = 4'd3;
  localparam logic [3:0]  MSG_STOPCCN      = 4'd4;
  localparam logic [14:0] SEND_WINDOW_RST  = 15'd4;

  typedef struct packed {
    op_t         op;
    logic [3:0]  msg_type;
    logic [15:0] rx_ns;
    logic [15:0] rx_nr;
  } item_t;

  typedef struct packed {
    logic [15:0] expected_ns;
    logic [15:0] next_send_ns;
    logic [15:0] peer_ack;
    logic        ack_pending;
    tun_state_t  tun_state;
  } chan_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] seq_ns;
    logic [15:0] seq_nr;
    tun_state_t  tunnel_state;
    logic        window_open;
    logic [31:0] stat_count;
  } result_t;

  // Serial number arithmetic: a lies below b when b - a is in 1..32767.
  function automatic logic seq_below(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = b - a;
    return (d != 16'd0) && !d[15];
  endfunction

endpackage

// ===== rtl/core/l2tp_control_sequencer_core.sv =====
`timescale 1ns / 1ps

// Sequence window of the control channel of one L2TPv2 tunnel.
// Request channel (req_valid / req_stall) carries one operation per beat:
// receive control, receive data, tick or send request, with msg_type,
// rx_ns and rx_nr. Response channel (rsp_valid / rsp_stall) returns exactly
// one beat per request: the class, the assigned or ZLB Ns, the expected Nr,
// the tunnel state, the window flag and, for a received message, the counter
// of its class (zero otherwise). A request sits in the input register and
// is resolved against the channel state on its way into the result register,
// which holds its response. One beat per cycle is sustained in both
// directions while the receiver does not stall.
// When the receiver stalls, the result register holds its beat; the input
// register still takes one more request, and then req_stall is raised.
// Synchronous reset empties both registers, clears all sequence numbers,
// counters and the pending acknowledgement, puts the tunnel in the waiting
// state and sets the send window to 4. cfg_wr_en writes send_window at once.
module l2tp_control_sequencer_core import l2tpcs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  op,
  input  logic [3:0]  msg_type,
  input  logic [15:0] rx_ns,
  input  logic [15:0] rx_nr,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [2:0]  kind,
  output logic [15:0] seq_ns,
  output logic [15:0] seq_nr,
  output logic [1:0]  tunnel_state,
  output logic        window_open,
  output logic [31:0] stat_count
);

  logic             s1_valid;
  item_t            s1_item;
  logic             advance;
  logic [14:0]      send_window;
  chan_state_t      st;
  chan_state_t      st_next;
  logic [3:0][31:0] counters;
  logic [3:0][31:0] counters_next;
  result_t          res;
  result_t          rsp;

  assign advance   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      send_window <= SEND_WINDOW_RST;
    end else if (cfg_wr_en) begin
      send_window <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s1_item <= '{op: op_t'(op), msg_type: msg_type, rx_ns: rx_ns, rx_nr: rx_nr};
    end
  end

  l2tpcs_update u_update (
    .item          (s1_item),
    .st            (st),
    .counters      (counters),
    .send_window   (send_window),
    .st_next       (st_next),
    .counters_next (counters_next),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= '{expected_ns: 16'd0, next_send_ns: 16'd0, peer_ack: 16'd0,
                    ack_pending: 1'b0, tun_state: TS_WAIT};
      counters <= '0;
    end else if (advance) begin
      st       <= st_next;
      counters <= counters_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= res;
    end
  end

  assign kind         = 3'(rsp.kind);
  assign seq_ns       = rsp.seq_ns;
  assign seq_nr       = rsp.seq_nr;
  assign tunnel_state = 2'(rsp.tunnel_state);
  assign window_open  = rsp.window_open;
  assign stat_count   = rsp.stat_count;

  // A terminated tunnel never leaves the terminated state until reset.
  a_term_sticky: assert property (@(posedge clk) disable iff (rst)
    st.tun_state == TS_TERM |=> st.tun_state == TS_TERM)
    else $error("tunnel left the terminated state");

  // The request side stalls only while the input register holds a beat
  // that cannot move on.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid && rsp_valid && rsp_stall)
    else $error("request stalled without a blocked response");

  // Only a send request reports an open window.
  a_window_kind: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && window_open |-> rsp.kind == KIND_NONE)
    else $error("window flag on a non-send response");

  // The next Ns to send moves only by one and only on an advancing send.
  a_ns_step: assert property (@(posedge clk) disable iff (rst)
    !(advance && s1_item.op == OP_SEND) |=> $stable(st.next_send_ns))
    else $error("next_send_ns changed without a send request");

endmodule

// ===== rtl/core/l2tpcs_update.sv =====
`timescale 1ns / 1ps

module l2tpcs_update import l2tpcs_pkg::*; (
  input  item_t             item,
  input  chan_state_t       st,
  input  logic [3:0][31:0]  counters,
  input  logic [14:0]       send_window,
  output chan_state_t       st_next,
  output logic [3:0][31:0]  counters_next,
  output result_t           res
);

  logic        count_en;
  logic [1:0]  cls;
  logic [15:0] limit;

  assign limit = st.peer_ack + {1'b0, send_window};

  always_comb begin
    st_next       = st;
    counters_next = counters;
    count_en      = 1'b0;
    res.kind        = KIND_NONE;
    res.seq_ns      = 16'd0;
    res.window_open = 1'b0;

    case (item.op)
      OP_RX_CTRL: begin
        count_en = 1'b1;
        if (seq_below(st.peer_ack, item.rx_nr)) begin
          st_next.peer_ack = item.rx_nr;
        end
        if (item.rx_ns == st.expected_ns) begin
          res.kind            = KIND_INORDER;
          st_next.expected_ns = item.rx_ns + 16'd1;
          st_next.ack_pending = 1'b1;
          // A terminated tunnel keeps its state whatever arrives.
          if (st.tun_state != TS_TERM) begin
            if (item.msg_type == MSG_SCCCN && st.tun_state == TS_WAIT) begin
              st_next.tun_state = TS_EST;
            end else if (item.msg_type == MSG_STOPCCN) begin
              st_next.tun_state = TS_TERM;
            end
          end
        end else if (seq_below(item.rx_ns, st.expected_ns)) begin
          res.kind            = KIND_DUP;
          st_next.ack_pending = 1'b1;
        end else begin
          res.kind = KIND_OOO;
        end
      end
      OP_RX_DATA: begin
        count_en = 1'b1;
        res.kind = KIND_DATA;
      end
      OP_TICK: begin
        if (st.ack_pending) begin
          res.kind            = KIND_ZLB;
          res.seq_ns          = st.next_send_ns;
          st_next.ack_pending = 1'b0;
        end
      end
      default: begin
        // The ZLB above reuses next_send_ns; only a send request consumes it.
        res.seq_ns           = st.next_send_ns;
        st_next.next_send_ns = st.next_send_ns + 16'd1;
        res.window_open      = seq_below(st.next_send_ns, limit);
      end
    endcase

    cls = 2'(res.kind);
    res.stat_count = 32'd0;
    if (count_en) begin
      counters_next[cls] = counters[cls] + 32'd1;
      res.stat_count     = counters_next[cls];
    end

    res.seq_nr       = st_next.expected_ns;
    res.tunnel_state = st_next.tun_state;
  end

endmodule
